/* rtl/semi_pkg.sv */
// Shared types, constants and codes for the servo eased move interpolator.
// Used by the controller, the datapath, the top level and the port checker.
package semi_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned ANGLE_W    = 8;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned INNER_W    = 20;
  localparam int unsigned NUM_SLOTS  = 4;

  // Channel count default and angle constants.
  localparam int unsigned CHANNELS_DEF = 4;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 8'd180;
  localparam logic [ANGLE_W-1:0] HOME_ANGLE = 8'd90;

  // Smoothstep constant 10.0 in Q4.16.
  localparam logic [INNER_W-1:0] INNER_BASE = 20'd655360;
  localparam logic [FRAC_W-1:0]  HALF_LSB   = 16'd32768;

  // Restoring divider: one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = FRAC_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHANNEL_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SHORT_MOVE_MS  = 1'd1;
  localparam logic [NUM_SLOTS-1:0] CHANNEL_ENABLE_RST = 4'd15;
  localparam logic [7:0]           SHORT_MOVE_MS_RST  = 8'd10;

  // Item kind codes.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [DUR_W-1:0]   length_ms;
    logic [ANGLE_W-1:0] target_0;
    logic [ANGLE_W-1:0] target_1;
    logic [ANGLE_W-1:0] target_2;
    logic [ANGLE_W-1:0] target_3;
    logic [DUR_W-1:0]   since_ms;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] pos_0;
    logic [ANGLE_W-1:0] pos_1;
    logic [ANGLE_W-1:0] pos_2;
    logic [ANGLE_W-1:0] pos_3;
    logic               done_res;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_MUL_Q,
    S_MUL_C,
    S_MUL_S,
    S_APPLY,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_move;
    logic jump;
    logic set_moving;
    logic clr_moving;
    logic div_init;
    logic div_step;
    logic mul_q;
    logic mul_c;
    logic mul_s;
    logic apply;
    logic emit;
    logic done;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;
    logic dur_zero;
    logic is_short;
    logic moving;
    logic el_ge_dur;
  } sts_t;

endpackage

/* rtl/semi_ctrl.sv */
// Controller state machine of the servo eased move interpolator.
// Depends on semi_pkg; drives the datapath through semi_pkg::cmd_t.
module semi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  semi_pkg::sts_t     sts,
  output semi_pkg::cmd_t     cmd
);

  semi_pkg::state_t                  state_r, state_nxt;
  logic [semi_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                              done_r, done_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              slot_free;

  assign in_stall  = (state_r != semi_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      semi_pkg::S_IDLE: begin
        if (in_valid) state_nxt = semi_pkg::S_EVAL;
      end
      semi_pkg::S_EVAL: begin
        if (sts.is_start) begin
          if (!sts.dur_zero && sts.is_short) state_nxt = semi_pkg::S_EMIT;
          else state_nxt = semi_pkg::S_IDLE;
        end else if (!sts.moving) begin
          state_nxt = semi_pkg::S_IDLE;
        end else if (sts.el_ge_dur) begin
          state_nxt = semi_pkg::S_EMIT;
        end else begin
          state_nxt = semi_pkg::S_DIV;
        end
      end
      semi_pkg::S_DIV: begin
        if (cnt_r == semi_pkg::DIV_CNT_W'(semi_pkg::DIV_STEPS - 1)) begin
          state_nxt = semi_pkg::S_MUL_Q;
        end
      end
      semi_pkg::S_MUL_Q: state_nxt = semi_pkg::S_MUL_C;
      semi_pkg::S_MUL_C: state_nxt = semi_pkg::S_MUL_S;
      semi_pkg::S_MUL_S: state_nxt = semi_pkg::S_APPLY;
      semi_pkg::S_APPLY: state_nxt = semi_pkg::S_EMIT;
      semi_pkg::S_EMIT: begin
        if (slot_free) state_nxt = semi_pkg::S_IDLE;
      end
      default: state_nxt = semi_pkg::S_IDLE;
    endcase
  end

  // Outputs and side registers.
  always_comb begin
    cmd         = '0;
    cnt_nxt     = cnt_r;
    done_nxt    = done_r;
    cmd.done    = done_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      semi_pkg::S_IDLE: begin
        cmd.capture = in_valid;
      end
      semi_pkg::S_EVAL: begin
        if (sts.is_start) begin
          if (!sts.dur_zero) begin
            cmd.load_move = 1'b1;
            if (sts.is_short) begin
              cmd.jump       = 1'b1;
              cmd.clr_moving = 1'b1;
              done_nxt       = 1'b1;
            end else begin
              cmd.set_moving = 1'b1;
            end
          end
        end else if (sts.moving) begin
          if (sts.el_ge_dur) begin
            cmd.jump       = 1'b1;
            cmd.clr_moving = 1'b1;
            done_nxt       = 1'b1;
          end else begin
            cmd.div_init = 1'b1;
            cnt_nxt      = '0;
            done_nxt     = 1'b0;
          end
        end
      end
      semi_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
      end
      semi_pkg::S_MUL_Q: cmd.mul_q = 1'b1;
      semi_pkg::S_MUL_C: cmd.mul_c = 1'b1;
      semi_pkg::S_MUL_S: cmd.mul_s = 1'b1;
      semi_pkg::S_APPLY: cmd.apply = 1'b1;
      semi_pkg::S_EMIT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= semi_pkg::S_IDLE;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/semi_dp.sv */
// Datapath of the servo eased move interpolator: item and configuration
// registers, channel positions, serial divider, smoothstep multipliers.
// Depends on semi_pkg; takes commands from semi_ctrl.
module semi_dp #(
  parameter int unsigned CHANNELS = semi_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  semi_pkg::in_item_t                in_data,
  input  logic                              cfg_we,
  input  logic [semi_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [semi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  semi_pkg::cmd_t                    cmd,
  output semi_pkg::sts_t                    sts,
  output semi_pkg::out_item_t               out_data
);

  localparam int unsigned AW = semi_pkg::ANGLE_W;
  localparam int unsigned DW = semi_pkg::DUR_W;
  localparam int unsigned FW = semi_pkg::FRAC_W;
  localparam int unsigned IW = semi_pkg::INNER_W;
  localparam int unsigned MW = AW + FW + 1;

  semi_pkg::in_item_t               item_r;
  logic [semi_pkg::NUM_SLOTS-1:0]   en_r;
  logic [7:0]                       short_r;
  logic [DW-1:0]                    dur_r;
  logic                             moving_r;

  logic [AW-1:0] cur_r   [CHANNELS];
  logic [AW-1:0] start_r [CHANNELS];
  logic [AW-1:0] goal_r  [CHANNELS];

  logic [DW-1:0] rem_r;
  logic [FW-1:0] t_r, q_r, cube_r, s_r;
  logic [IW-1:0] inner_r;

  logic [AW-1:0] tg_raw [semi_pkg::NUM_SLOTS];
  logic [AW-1:0] pos_w  [semi_pkg::NUM_SLOTS];
  semi_pkg::out_item_t out_r;

  // Divider step.
  logic [DW:0]     div_sh;
  logic            div_ge;
  logic [DW:0]     div_diff;
  // Multiplier products.
  logic [2*FW-1:0] prod_q, prod_c;
  logic [FW+IW-1:0] prod_s;
  logic [IW-1:0]   s_wide;
  logic [IW-1:0]   inner_w;

  assign tg_raw[0] = item_r.target_0;
  assign tg_raw[1] = item_r.target_1;
  assign tg_raw[2] = item_r.target_2;
  assign tg_raw[3] = item_r.target_3;

  assign sts.is_start  = (item_r.kind == semi_pkg::KIND_START);
  assign sts.dur_zero  = (item_r.length_ms == '0);
  assign sts.is_short  = (item_r.length_ms <= {{(DW-8){1'b0}}, short_r});
  assign sts.moving    = moving_r;
  assign sts.el_ge_dur = (item_r.since_ms >= dur_r);

  assign div_sh   = {rem_r, 1'b0};
  assign div_ge   = (div_sh >= {1'b0, dur_r});
  assign div_diff = div_sh - {1'b0, dur_r};

  assign prod_q  = t_r * t_r;
  assign prod_c  = q_r * t_r;
  // 10 + 6q - 15t stays positive for t below one, so 20-bit wrap is exact.
  assign inner_w = semi_pkg::INNER_BASE
                 + ({{(IW-FW-2){1'b0}}, q_r, 2'b00} + {{(IW-FW-1){1'b0}}, q_r, 1'b0})
                 - ({{(IW-FW-4){1'b0}}, t_r, 4'b0000} - {{(IW-FW){1'b0}}, t_r});
  assign prod_s  = cube_r * inner_r;
  assign s_wide  = prod_s[FW+IW-1:FW];

  // Configuration and move control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= semi_pkg::CHANNEL_ENABLE_RST;
      short_r  <= semi_pkg::SHORT_MOVE_MS_RST;
      dur_r    <= '0;
      moving_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          semi_pkg::CFG_IDX_CHANNEL_ENABLE: en_r <= cfg_wdata[semi_pkg::NUM_SLOTS-1:0];
          semi_pkg::CFG_IDX_SHORT_MOVE_MS:  short_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (cmd.load_move)  dur_r <= item_r.length_ms;
      if (cmd.set_moving) moving_r <= 1'b1;
      if (cmd.clr_moving) moving_r <= 1'b0;
    end
  end

  // Item capture, divider and polynomial stages.
  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.div_init) begin
      rem_r <= item_r.since_ms;
      t_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? div_diff[DW-1:0] : div_sh[DW-1:0];
      t_r   <= {t_r[FW-2:0], div_ge};
    end
    if (cmd.mul_q) q_r <= prod_q[2*FW-1:FW];
    if (cmd.mul_c) begin
      cube_r  <= prod_c[2*FW-1:FW];
      inner_r <= inner_w;
    end
    if (cmd.mul_s) s_r <= (s_wide > {{(IW-FW){1'b0}}, {FW{1'b1}}}) ? {FW{1'b1}} : s_wide[FW-1:0];
    if (cmd.emit) out_r <= {pos_w[0], pos_w[1], pos_w[2], pos_w[3], cmd.done};
  end

  // One lane per channel.
  for (genvar j = 0; j < semi_pkg::NUM_SLOTS; j++) begin : g_slot
    if (j < CHANNELS) begin : g_lane
      logic [AW-1:0]    tg_sat, goal_nxt, mag, step_v;
      logic             up;
      logic [AW+FW:0]   prod_m;

      assign tg_sat   = (tg_raw[j] > semi_pkg::ANGLE_MAX) ? semi_pkg::ANGLE_MAX : tg_raw[j];
      assign goal_nxt = cmd.load_move ? tg_sat : goal_r[j];
      assign up       = (goal_r[j] >= start_r[j]);
      assign mag      = up ? (goal_r[j] - start_r[j]) : (start_r[j] - goal_r[j]);
      // The delta times s needs the full 24-bit product before rounding.
      assign prod_m   = MW'(mag) * MW'(s_r) + MW'(semi_pkg::HALF_LSB);
      assign step_v   = prod_m[AW+FW-1:FW];
      assign pos_w[j] = cur_r[j];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cur_r[j]   <= semi_pkg::HOME_ANGLE;
          start_r[j] <= semi_pkg::HOME_ANGLE;
          goal_r[j]  <= semi_pkg::HOME_ANGLE;
        end else if (en_r[j]) begin
          if (cmd.load_move) begin
            start_r[j] <= cur_r[j];
            goal_r[j]  <= tg_sat;
          end
          if (cmd.jump) begin
            cur_r[j] <= goal_nxt;
          end else if (cmd.apply) begin
            cur_r[j] <= up ? (start_r[j] + step_v) : (start_r[j] - step_v);
          end
        end
      end
    end else begin : g_none
      assign pos_w[j] = semi_pkg::HOME_ANGLE;
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/servo_eased_move_interpolator_core.sv */
// Top level of the four-channel servo eased move interpolator.
// Depends on semi_pkg, semi_ctrl and semi_dp.
//
// A start transaction (kind 0) loads a move: every enabled channel takes its
// current angle as the start point and its target, clamped to 180 degrees,
// as the goal. A zero duration is ignored; a duration at or below
// short_move_ms jumps the enabled channels straight to their goals and
// returns one result with done_res set, and a longer duration starts a move
// and returns nothing. Each tick transaction (kind 1) carries the elapsed
// milliseconds: while a move runs and elapsed is below the duration, each
// enabled channel goes to start + (goal - start) * s, with s the quintic
// smoothstep 6t^5 - 15t^4 + 10t^3 of t = elapsed / duration in unsigned
// Q0.16, rounded half away from zero, and one result with done_res clear is
// returned; once elapsed reaches the duration the channels land on their
// goals and the result carries done_res set. Ticks with no move running are
// dropped. Disabled channels keep their angle and still report it, and
// channels at or above CHANNELS report the 90 degree home angle.
// The block handles one transaction at a time. An easing tick runs the
// restoring divider that forms t one quotient bit per cycle, then three
// multiplier stages for t^2, t^3 and the polynomial, one step to scale the
// four deltas and one to load the result register.
// The result register frees the input side, so a new transaction is taken
// while a result waits; only a second result waits for the first to leave.
// Configuration is a plain write port (index 0 channel_enable, index 1
// short_move_ms) and is to be written only while the block is idle.
module servo_eased_move_interpolator_core #(
  parameter int unsigned CHANNELS = semi_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  semi_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output semi_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [semi_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [semi_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  semi_pkg::cmd_t cmd;
  semi_pkg::sts_t sts;

  // Sequencing of each transaction and the result handshake.
  semi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Channel state, divider and smoothstep arithmetic.
  semi_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

/* rtl/semi_chk.sv */
// Port-level checker for the servo eased move interpolator top level.
// Depends on semi_pkg; attached to the top level with a bind statement.
module semi_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input semi_pkg::out_item_t out_data
);

  // A waiting result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The block is busy in the cycle after each accepted transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // Reported angles never exceed the servo range.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pos_0 <= semi_pkg::ANGLE_MAX && out_data.pos_1 <= semi_pkg::ANGLE_MAX
                  && out_data.pos_2 <= semi_pkg::ANGLE_MAX
                  && out_data.pos_3 <= semi_pkg::ANGLE_MAX)
    else $error("position out of range");

  // A result only disappears after it has been taken.
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped before transaction");

endmodule

bind servo_eased_move_interpolator_core semi_chk u_semi_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for servo_eased_move_interpolator_core, four channels.
// Needs semi_pkg and the core RTL; it holds its own predictor of the eased positions.

module tb_top;

  // Idle time after the last expected result, long enough for any transaction
  // still in flight in the core to finish.
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 140;
  localparam int unsigned PHASES         = 5;

  // Tracks the commanded angles of the four channels and queues the position
  // reports that the core must return, in order.
  class servo_tracker;
    logic [3:0]  enable_mask;
    logic [7:0]  short_ms;
    logic [7:0]  cur_pos  [semi_pkg::NUM_SLOTS];
    logic [7:0]  from_pos [semi_pkg::NUM_SLOTS];
    logic [7:0]  goal_pos [semi_pkg::NUM_SLOTS];
    logic [15:0] span_ms;
    bit          in_motion;
    semi_pkg::out_item_t pending [$];
    int unsigned mismatches, surplus, checked, eased, landed;

    function new();
      enable_mask = semi_pkg::CHANNEL_ENABLE_RST;
      short_ms    = semi_pkg::SHORT_MOVE_MS_RST;
      foreach (cur_pos[j]) begin
        cur_pos[j]  = semi_pkg::HOME_ANGLE;
        from_pos[j] = semi_pkg::HOME_ANGLE;
        goal_pos[j] = semi_pkg::HOME_ANGLE;
      end
      span_ms   = '0;
      in_motion = 1'b0;
    endfunction

    // Quintic smoothstep 6t^5 - 15t^4 + 10t^3 with t and the result in Q0.16.
    function logic [15:0] smoothstep_q16(logic [15:0] t);
      logic [63:0] sq, cube, inner, s;
      sq    = (64'(t) * 64'(t)) >> 16;
      cube  = (sq * 64'(t)) >> 16;
      inner = 64'd655360 + 64'd6 * sq - 64'd15 * 64'(t);
      s     = (cube * inner) >> 16;
      return (s > 64'd65535) ? 16'hFFFF : s[15:0];
    endfunction

    function void queue_positions(bit done);
      semi_pkg::out_item_t want;
      want.pos_0    = cur_pos[0];
      want.pos_1    = cur_pos[1];
      want.pos_2    = cur_pos[2];
      want.pos_3    = cur_pos[3];
      want.done_res = done;
      pending.push_back(want);
    endfunction

    function void settle_on_goals();
      for (int j = 0; j < semi_pkg::NUM_SLOTS; j++)
        if (enable_mask[j]) cur_pos[j] = goal_pos[j];
      in_motion = 1'b0;
      landed++;
      queue_positions(1'b1);
    endfunction

    // Applies one accepted command; returns 0 when the core simply drops it.
    function bit take_command(semi_pkg::in_item_t cmd);
      logic [7:0]  tgt [semi_pkg::NUM_SLOTS];
      logic [31:0] frac, stepv;
      logic [15:0] s;
      logic [7:0]  mag;
      tgt[0] = cmd.target_0;
      tgt[1] = cmd.target_1;
      tgt[2] = cmd.target_2;
      tgt[3] = cmd.target_3;
      if (cmd.kind == semi_pkg::KIND_START) begin
        if (cmd.length_ms == '0) return 1'b0;
        for (int j = 0; j < semi_pkg::NUM_SLOTS; j++) begin
          if (enable_mask[j]) begin
            from_pos[j] = cur_pos[j];
            goal_pos[j] = (tgt[j] > semi_pkg::ANGLE_MAX) ? semi_pkg::ANGLE_MAX : tgt[j];
          end
        end
        span_ms = cmd.length_ms;
        if (cmd.length_ms <= 16'(short_ms)) settle_on_goals();
        else in_motion = 1'b1;
        return 1'b1;
      end
      if (!in_motion) return 1'b0;
      if (span_ms == '0 || cmd.since_ms >= span_ms) begin
        settle_on_goals();
        return 1'b1;
      end
      frac = {cmd.since_ms, 16'h0000} / {16'h0000, span_ms};
      s    = smoothstep_q16(frac[15:0]);
      for (int j = 0; j < semi_pkg::NUM_SLOTS; j++) begin
        if (enable_mask[j]) begin
          mag   = (goal_pos[j] >= from_pos[j]) ? goal_pos[j] - from_pos[j]
                                               : from_pos[j] - goal_pos[j];
          stepv = (32'(mag) * 32'(s) + 32'd32768) >> 16;
          cur_pos[j] = (goal_pos[j] >= from_pos[j]) ? from_pos[j] + stepv[7:0]
                                                    : from_pos[j] - stepv[7:0];
        end
      end
      eased++;
      queue_positions(1'b0);
      return 1'b1;
    endfunction

    function void compare_positions(semi_pkg::out_item_t got);
      semi_pkg::out_item_t want;
      if (pending.size() == 0) begin
        surplus++;
        if (mismatches + surplus <= 10)
          $display("%0t: result with none expected: pos %0d %0d %0d %0d done %0b",
                   $time, got.pos_0, got.pos_1, got.pos_2, got.pos_3, got.done_res);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.pos_0 !== want.pos_0 || got.pos_1 !== want.pos_1 ||
          got.pos_2 !== want.pos_2 || got.pos_3 !== want.pos_3 ||
          got.done_res !== want.done_res) begin
        mismatches++;
        if (mismatches + surplus <= 10)
          $display("%0t: expected pos %0d %0d %0d %0d done %0b, got %0d %0d %0d %0d done %0b",
                   $time, want.pos_0, want.pos_1, want.pos_2, want.pos_3, want.done_res,
                   got.pos_0, got.pos_1, got.pos_2, got.pos_3, got.done_res);
      end
    endfunction
  endclass

  // Every input of the core is known from time zero.
  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  semi_pkg::in_item_t              in_data   = '0;
  logic                            out_stall = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [semi_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [semi_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_stall;
  logic                            out_valid;
  semi_pkg::out_item_t             out_data;

  servo_tracker tracker = new();
  bit           calm         = 1'b0;  // no idling on either side while set
  int unsigned  hold_left    = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  acted        = 0;     // commands that changed state or gave a result

  servo_eased_move_interpolator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Result side. The report is sampled at the edge, before any update of this
  // step lands, then the stall for the next cycle is chosen. Mostly single
  // stall cycles at about 12 percent, with a rare long hold so that stalls
  // cover the whole easing computation and a waiting result register.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.compare_positions(out_data);
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      out_stall <= 1'b1;
      hold_left <= $urandom_range(20, 60);
    end else begin
      out_stall <= ($urandom_range(0, 99) < 12);
    end
  end

  // Watchdog: any transaction on either channel, a register write or reset
  // counts as progress.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [7:0] pick_angle();
    // Mostly legal angles, sometimes above 180 to exercise the clamp.
    if ($urandom_range(0, 99) < 15) return 8'($urandom_range(181, 255));
    return 8'($urandom_range(0, 180));
  endfunction

  // Start command; the elapsed field is unused and carries noise.
  function automatic semi_pkg::in_item_t make_start(logic [15:0] dur, logic [31:0] goals);
    semi_pkg::in_item_t it;
    it.kind      = semi_pkg::KIND_START;
    it.length_ms = dur;
    it.target_0  = goals[31:24];
    it.target_1  = goals[23:16];
    it.target_2  = goals[15:8];
    it.target_3  = goals[7:0];
    it.since_ms  = 16'($urandom);
    return it;
  endfunction

  // Tick command; duration and targets are unused and carry noise.
  function automatic semi_pkg::in_item_t make_tick(logic [15:0] el);
    semi_pkg::in_item_t it;
    it.kind      = semi_pkg::KIND_TICK;
    it.length_ms = 16'($urandom);
    it.target_0  = 8'($urandom);
    it.target_1  = 8'($urandom);
    it.target_2  = 8'($urandom);
    it.target_3  = 8'($urandom);
    it.since_ms  = el;
    return it;
  endfunction

  function automatic logic [31:0] random_goals();
    return {pick_angle(), pick_angle(), pick_angle(), pick_angle()};
  endfunction

  // Offers one command and holds it until the core takes it. Valid stays high
  // from one transaction to the next unless an idle gap is inserted first.
  task automatic send_command(input semi_pkg::in_item_t cmd);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (tracker.take_command(cmd)) acted++;
  endtask

  // Stops sending, waits for every expected report, then lets a command that
  // gives no report finish inside the core.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; only called while idle.
  task automatic write_settings(input logic [3:0] mask, input logic [7:0] short_lim);
    cfg_we    <= 1'b1;
    cfg_idx   <= semi_pkg::CFG_IDX_CHANNEL_ENABLE;
    cfg_wdata <= semi_pkg::CFG_DATA_W'(mask);
    @(posedge clk);
    cfg_idx   <= semi_pkg::CFG_IDX_SHORT_MOVE_MS;
    cfg_wdata <= short_lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.enable_mask = mask;
    tracker.short_ms    = short_lim;
  endtask

  // One move: a start with random goals followed by ticks of rising elapsed
  // time until the move lands. Some moves are cut short so that the next one
  // restarts from mid-flight, and a few picks are plain noise commands.
  task automatic run_move();
    int unsigned pick, dur, el, reach, lim;
    pick = $urandom_range(0, 99);
    lim  = tracker.short_ms;
    if (pick < 3) begin
      send_command(make_start(16'd0, random_goals()));
      return;
    end
    if (pick < 6) begin
      send_command(make_tick(16'($urandom)));
      return;
    end
    if (pick < 16 && lim != 0) dur = $urandom_range(1, lim);
    else if (pick < 22) dur = $urandom_range(lim + 1, 65535);
    else dur = $urandom_range(lim + 1, lim + 300);
    send_command(make_start(16'(dur), random_goals()));
    if (dur <= lim) return;
    // Strides average a sixth of the move, so a move sees a handful of ticks.
    reach = dur / 6 * 2 + 1;
    el    = 0;
    while (el < dur) begin
      if ($urandom_range(0, 99) < 6) return;
      el += $urandom_range(0, reach);
      send_command(make_tick((el > 65535) ? 16'hFFFF : 16'(el)));
    end
    // Now and then the sender waits for every report before going on.
    if ($urandom_range(0, 99) < 4) drain_results();
  endtask

  initial begin
    logic [3:0]  mask_set  [PHASES];
    logic [7:0]  limit_set [PHASES];
    int unsigned stop_at;
    // Register settings per phase: reset values, everything off with no short
    // moves, all channels with the longest short limit, a random mix, and a
    // sparse mask with a small limit.
    mask_set  = '{4'd15, 4'd0, 4'd15, 4'($urandom_range(1, 14)), 4'd10};
    limit_set = '{8'd10, 8'd0, 8'd255, 8'($urandom_range(1, 254)), 8'd3};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the reset register values.
    send_command(make_tick(16'd1234));                       // tick with no move
    send_command(make_start(16'd0, {8'd200, 8'd1, 8'd2, 8'd3}));    // zero duration
    send_command(make_start(16'd10, {8'd0, 8'd180, 8'd255, 8'd181})); // short, clamps
    send_command(make_start(16'd11, {8'd180, 8'd0, 8'd90, 8'd45}));   // shortest easing
    send_command(make_tick(16'd0));
    send_command(make_tick(16'd5));
    send_command(make_tick(16'd10));
    send_command(make_tick(16'd11));                         // lands exactly on time
    send_command(make_tick(16'd3));                          // after landing: dropped
    send_command(make_start(16'hFFFF, {8'd0, 8'd180, 8'd0, 8'd180}));
    send_command(make_tick(16'd1));
    send_command(make_tick(16'd32768));
    send_command(make_tick(16'hFFFE));
    send_command(make_start(16'd1000, {8'd90, 8'd90, 8'd255, 8'd0})); // restart mid-move
    send_command(make_tick(16'd500));
    send_command(make_start(16'd0, {8'd7, 8'd7, 8'd7, 8'd7}));       // zero while moving
    send_command(make_tick(16'hFFFF));
    send_command(make_start(16'd1, {8'd45, 8'd135, 8'd10, 8'd170}));
    drain_results();

    // Random part, one phase per register setting. The middle phase runs
    // with no idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      calm <= (p == 2);
      write_settings(mask_set[p], limit_set[p]);
      stop_at = acted + PHASE_ITEMS;
      while (acted < stop_at) run_move();
      drain_results();
    end

    $display("Covered %0d commands that acted: %0d eased ticks, %0d landings or jumps,",
             acted, tracker.eased, tracker.landed);
    $display("over %0d register settings; %0d reports compared, %0d wrong, %0d unasked, %0d owed.",
             PHASES, tracker.checked, tracker.mismatches, tracker.surplus,
             tracker.pending.size());
    if (tracker.mismatches == 0 && tracker.surplus == 0 && tracker.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
